FILE: rtl/hsne_pkg.sv
// Shared types, widths and constants of the hole sensor note encoder.
// Used by every rtl file; depends on nothing.
package hsne_pkg;

    localparam int HOLES       = 5;
    localparam int CAL_SAMPLES = 5;
    localparam int SAMPLE_MAX  = 4095;

    localparam int SAMPLE_W  = 12;
    localparam int GAIN_W    = 6;
    localparam int TRIP_W    = 18;
    localparam int MS_W      = 8;
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 18;

    localparam int SUM_W     = SAMPLE_W + $clog2(CAL_SAMPLES + 1);
    localparam int CALCNT_W  = $clog2(CAL_SAMPLES + 1);
    localparam int RECIP_SH  = SUM_W + 4;
    localparam longint RECIP = ((64'd1 << RECIP_SH) + CAL_SAMPLES - 1) / CAL_SAMPLES;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int PROD_W    = SUM_W + RECIP_W;

    localparam int MAX_MSG    = 3;
    localparam int PUSH_W     = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [NOTE_W-1:0] NOTE_TOP    = 7'd127;
    localparam logic [VEL_W-1:0]  VEL_ON      = 7'd127;
    localparam logic [VEL_W-1:0]  VEL_OFF     = 7'd0;
    localparam logic [3:0]        OCTAVE_STEP = 4'd12;

    localparam logic [GAIN_W-1:0] GAIN_RESET [HOLES] = '{6'd5, 6'd8, 6'd20, 6'd5, 6'd5};
    localparam logic [TRIP_W-1:0] TRIP_RESET     = TRIP_W'(SAMPLE_MAX);
    localparam logic [MS_W-1:0]   DEBOUNCE_RESET = 8'd20;
    localparam logic [NOTE_W-1:0] ROOT_RESET     = 7'd36;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN0    = 3'd0,
        REG_GAIN1    = 3'd1,
        REG_GAIN2    = 3'd2,
        REG_GAIN3    = 3'd3,
        REG_GAIN4    = 3'd4,
        REG_TRIP     = 3'd5,
        REG_DEBOUNCE = 3'd6,
        REG_ROOT     = 3'd7
    } cfg_idx_t;

    typedef enum logic {
        FUNC_CALIB = 1'b0,
        FUNC_SCAN  = 1'b1
    } func_t;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
        logic              last;
    } msg_t;

    typedef struct packed {
        logic [PUSH_W-1:0]           cnt;
        msg_t [MAX_MSG-1:0]          words;
    } push_t;

    typedef struct packed {
        logic             room;
        logic [LVL_W-1:0] level;
    } fifo_status_t;

endpackage

FILE: rtl/hsne_ifs.sv
// Valid/ready channel interfaces: sensor items, note messages, register writes.
// Depends on hsne_pkg for field widths.
interface hsne_item_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [hsne_pkg::SAMPLE_W-1:0] sample0;
    logic [hsne_pkg::SAMPLE_W-1:0] sample1;
    logic [hsne_pkg::SAMPLE_W-1:0] sample2;
    logic [hsne_pkg::SAMPLE_W-1:0] sample3;
    logic [hsne_pkg::SAMPLE_W-1:0] sample4;
    logic                          air_level;
    logic [hsne_pkg::MS_W-1:0]     elapsed_ms;

    modport source (output valid, func, sample0, sample1, sample2, sample3, sample4,
                    air_level, elapsed_ms, input ready);
    modport sink (input valid, func, sample0, sample1, sample2, sample3, sample4,
                  air_level, elapsed_ms, output ready);
endinterface

interface hsne_msg_if;
    logic                        valid;
    logic                        ready;
    logic [hsne_pkg::NOTE_W-1:0] note;
    logic [hsne_pkg::VEL_W-1:0]  velocity;
    logic                        last_message;

    modport source (output valid, note, velocity, last_message, input ready);
    modport sink (input valid, note, velocity, last_message, output ready);
endinterface

interface hsne_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [hsne_pkg::CFG_IDX_W-1:0] index;
    logic [hsne_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/hsne_lane.sv
// One hole lane: baseline calibration and covered detection.
// Depends on hsne_pkg.
module hsne_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [hsne_pkg::SAMPLE_W-1:0] sample,
    input  logic [hsne_pkg::GAIN_W-1:0]   gain,
    input  logic [hsne_pkg::TRIP_W-1:0]   trip,
    input  logic                          cal_en,
    input  logic                          cal_done,
    output logic                          covered
);

    logic [hsne_pkg::SAMPLE_W-1:0] baseline_reg;
    logic [hsne_pkg::SAMPLE_W-1:0] baseline_next;
    logic [hsne_pkg::SUM_W-1:0]    sum_reg;
    logic [hsne_pkg::SUM_W-1:0]    sum_next;
    logic [hsne_pkg::SUM_W-1:0]    sum_acc;
    logic [hsne_pkg::PROD_W-1:0]   mean_prod;
    logic [hsne_pkg::SAMPLE_W:0]   drop;
    logic [hsne_pkg::TRIP_W-1:0]   scaled;

    assign sum_acc   = sum_reg + hsne_pkg::SUM_W'(sample);
    assign mean_prod = hsne_pkg::PROD_W'(sum_acc)
                     * hsne_pkg::PROD_W'(hsne_pkg::RECIP);

    always_comb
    begin
        baseline_next = baseline_reg;
        sum_next      = sum_reg;
        if (cal_en)
        begin
            if (cal_done)
            begin
                baseline_next = mean_prod[hsne_pkg::RECIP_SH +: hsne_pkg::SAMPLE_W];
                sum_next      = '0;
            end
            else
            begin
                sum_next = sum_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            baseline_reg <= baseline_next;
            sum_reg      <= sum_next;
        end
    end

    assign drop    = {1'b0, baseline_reg} - {1'b0, sample};
    assign scaled  = hsne_pkg::TRIP_W'(drop[hsne_pkg::SAMPLE_W-1:0])
                   * hsne_pkg::TRIP_W'(gain);
    assign covered = !drop[hsne_pkg::SAMPLE_W] && (scaled > trip);

endmodule

FILE: rtl/hsne_encode.sv
// Merge stage: note encode from the lanes' covered bits, air debounce, message build.
// Depends on hsne_pkg.
module hsne_encode (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [hsne_pkg::HOLES-1:0]   covered,
    input  logic                         air_level,
    input  logic [hsne_pkg::MS_W-1:0]    elapsed_ms,
    input  logic [hsne_pkg::NOTE_W-1:0]  root_note,
    input  logic [hsne_pkg::MS_W-1:0]    debounce_ms,
    output hsne_pkg::push_t              push
);

    logic [hsne_pkg::NOTE_W-1:0] cur_note_reg;
    logic [hsne_pkg::NOTE_W-1:0] cur_note_next;
    logic                        playing_reg;
    logic                        playing_next;
    logic                        air_stable_reg;
    logic                        air_stable_next;
    logic                        air_prev_reg;
    logic                        air_prev_next;
    logic [hsne_pkg::MS_W-1:0]   unch_reg;
    logic [hsne_pkg::MS_W-1:0]   unch_next;

    logic [2:0]                  octave;
    logic [1:0]                  low;
    logic [hsne_pkg::NOTE_W:0]   raw_note;
    logic [hsne_pkg::NOTE_W-1:0] note;
    logic [hsne_pkg::MS_W:0]     timer_sum;
    logic [hsne_pkg::MS_W-1:0]   interval;
    logic                        has_chg;
    logic                        has_air;
    logic [hsne_pkg::VEL_W-1:0]  air_vel;

    assign octave   = covered[2:0];
    assign low      = covered[4:3];
    assign raw_note = {1'b0, root_note}
                    + (hsne_pkg::NOTE_W+1)'(octave) * (hsne_pkg::NOTE_W+1)'(hsne_pkg::OCTAVE_STEP)
                    + (hsne_pkg::NOTE_W+1)'(low);
    assign note     = (raw_note > (hsne_pkg::NOTE_W+1)'(hsne_pkg::NOTE_TOP))
                    ? hsne_pkg::NOTE_TOP : raw_note[hsne_pkg::NOTE_W-1:0];

    assign timer_sum = {1'b0, unch_reg} + {1'b0, elapsed_ms};
    assign interval  = playing_reg ? debounce_ms : '0;
    assign has_chg   = playing_reg && (note != cur_note_reg);
    assign air_vel   = (air_level == 1'b0) ? hsne_pkg::VEL_ON : hsne_pkg::VEL_OFF;

    always_comb
    begin
        cur_note_next = note;
        air_prev_next = air_prev_reg;
        unch_next     = timer_sum[hsne_pkg::MS_W] ? '1 : timer_sum[hsne_pkg::MS_W-1:0];
        if (air_level != air_prev_reg)
        begin
            air_prev_next = air_level;
            unch_next     = '0;
        end
        has_air         = (air_level != air_stable_reg) && (unch_next >= interval);
        air_stable_next = has_air ? air_level : air_stable_reg;
        playing_next    = has_air ? (air_level == 1'b0) : playing_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_note_reg   <= '0;
            playing_reg    <= 1'b0;
            air_stable_reg <= 1'b1;
            air_prev_reg   <= 1'b1;
            unch_reg       <= '0;
        end
        else if (en)
        begin
            cur_note_reg   <= cur_note_next;
            playing_reg    <= playing_next;
            air_stable_reg <= air_stable_next;
            air_prev_reg   <= air_prev_next;
            unch_reg       <= unch_next;
        end
    end

    always_comb
    begin
        push.cnt = {has_chg, 1'b0} + hsne_pkg::PUSH_W'(has_air);
        if (has_chg)
        begin
            push.words[0] = '{note: cur_note_reg, velocity: hsne_pkg::VEL_OFF, last: 1'b0};
        end
        else
        begin
            push.words[0] = '{note: note, velocity: air_vel, last: 1'b1};
        end
        push.words[1] = '{note: note, velocity: hsne_pkg::VEL_ON, last: !has_air};
        push.words[2] = '{note: note, velocity: air_vel, last: 1'b1};
    end

endmodule

FILE: rtl/hsne_fifo.sv
// Message queue, merge stage to message port; one word out per cycle when ready.
// Depends on hsne_pkg and hsne_msg_if.
module hsne_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_en,
    input  hsne_pkg::push_t        push,
    output hsne_pkg::fifo_status_t status,
    hsne_msg_if.source             msg
);

    hsne_pkg::msg_t                mem_reg [hsne_pkg::FIFO_DEPTH];
    logic [hsne_pkg::PTR_W-1:0]    wr_ptr_reg;
    logic [hsne_pkg::PTR_W-1:0]    rd_ptr_reg;
    logic [hsne_pkg::LVL_W-1:0]    level_reg;
    logic [hsne_pkg::LVL_W-1:0]    level_next;
    logic [hsne_pkg::PUSH_W-1:0]   push_cnt;
    logic                          pop;
    hsne_pkg::msg_t                head;

    assign push_cnt = push_en ? push.cnt : '0;
    assign pop      = msg.valid && msg.ready;
    assign head     = mem_reg[rd_ptr_reg];

    assign msg.valid        = (level_reg != '0);
    assign msg.note         = head.note;
    assign msg.velocity     = head.velocity;
    assign msg.last_message = head.last;

    assign level_next   = level_reg - hsne_pkg::LVL_W'(pop) + hsne_pkg::LVL_W'(push_cnt);
    assign status.level = level_reg;
    assign status.room  = ((level_reg - hsne_pkg::LVL_W'(pop)) + hsne_pkg::LVL_W'(hsne_pkg::MAX_MSG))
                          <= hsne_pkg::LVL_W'(hsne_pkg::FIFO_DEPTH);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < hsne_pkg::MAX_MSG; k++)
        begin
            if (hsne_pkg::PUSH_W'(k) < push_cnt)
            begin
                mem_reg[wr_ptr_reg + hsne_pkg::PTR_W'(k)] <= push.words[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + hsne_pkg::PTR_W'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + hsne_pkg::PTR_W'(pop);
            level_reg  <= level_next;
        end
    end

endmodule

FILE: rtl/hole_sensor_note_encoder_top.sv
// Top level of the hole sensor note encoder: registers, lanes, merge stage, queue.
// Depends on hsne_pkg, hsne_ifs, hsne_lane, hsne_encode and hsne_fifo.
//
// Takes one sensor word per clock unless a scan waits for queue room. Five hole
// lanes compare each sample against its calibrated baseline in the accept cycle
// (calibration words are absorbed there and give no message); the covered bits
// are registered, and once the queue has room the merge stage encodes the note,
// debounces the air input and pushes zero to three message words into a four-entry
// queue. The message port drains one word per cycle while ready, which sets the
// sustained rate: one scan word per cycle while scans produce no messages, otherwise
// one per message. Register writes are taken every cycle and belong to idle periods.
module hole_sensor_note_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    hsne_item_if.sink   item,
    hsne_msg_if.source  msg,
    hsne_cfg_if.sink    cfg
);

    logic [hsne_pkg::GAIN_W-1:0]   gain_reg [hsne_pkg::HOLES];
    logic [hsne_pkg::TRIP_W-1:0]   trip_reg;
    logic [hsne_pkg::MS_W-1:0]     debounce_reg;
    logic [hsne_pkg::NOTE_W-1:0]   root_reg;

    logic [hsne_pkg::CALCNT_W-1:0] cal_cnt_reg;
    logic                          s1_valid_reg;
    logic [hsne_pkg::HOLES-1:0]    covered_reg;
    logic                          air_reg;
    logic [hsne_pkg::MS_W-1:0]     elapsed_reg;

    logic [hsne_pkg::SAMPLE_W-1:0] samples [hsne_pkg::HOLES];
    logic [hsne_pkg::HOLES-1:0]    covered;
    logic                          accept;
    logic                          cal_en;
    logic                          cal_done;
    logic                          s2_take;
    hsne_pkg::push_t               push;
    hsne_pkg::fifo_status_t        fifo_st;

    assign samples[0] = item.sample0;
    assign samples[1] = item.sample1;
    assign samples[2] = item.sample2;
    assign samples[3] = item.sample3;
    assign samples[4] = item.sample4;

    assign s2_take    = s1_valid_reg && fifo_st.room;
    assign item.ready = !s1_valid_reg || s2_take;
    assign accept     = item.valid && item.ready;
    assign cal_en     = accept && (item.func == hsne_pkg::FUNC_CALIB);
    assign cal_done   = (cal_cnt_reg == hsne_pkg::CALCNT_W'(hsne_pkg::CAL_SAMPLES - 1));
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int h = 0; h < hsne_pkg::HOLES; h++)
            begin
                gain_reg[h] <= hsne_pkg::GAIN_RESET[h];
            end
            trip_reg     <= hsne_pkg::TRIP_RESET;
            debounce_reg <= hsne_pkg::DEBOUNCE_RESET;
            root_reg     <= hsne_pkg::ROOT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                hsne_pkg::REG_GAIN0,
                hsne_pkg::REG_GAIN1,
                hsne_pkg::REG_GAIN2,
                hsne_pkg::REG_GAIN3,
                hsne_pkg::REG_GAIN4:  gain_reg[cfg.index] <= cfg.data[hsne_pkg::GAIN_W-1:0];
                hsne_pkg::REG_TRIP:     trip_reg     <= cfg.data[hsne_pkg::TRIP_W-1:0];
                hsne_pkg::REG_DEBOUNCE: debounce_reg <= cfg.data[hsne_pkg::MS_W-1:0];
                hsne_pkg::REG_ROOT:     root_reg     <= cfg.data[hsne_pkg::NOTE_W-1:0];
                default:                trip_reg     <= trip_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cal_en)
            begin
                cal_cnt_reg <= cal_done ? '0 : cal_cnt_reg + 1'b1;
            end
            if (accept && (item.func == hsne_pkg::FUNC_SCAN))
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s2_take)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (item.func == hsne_pkg::FUNC_SCAN))
        begin
            covered_reg <= covered;
            air_reg     <= item.air_level;
            elapsed_reg <= item.elapsed_ms;
        end
    end

    for (genvar h = 0; h < hsne_pkg::HOLES; h++)
    begin : g_lane
        hsne_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .sample   (samples[h]),
            .gain     (gain_reg[h]),
            .trip     (trip_reg),
            .cal_en   (cal_en),
            .cal_done (cal_done),
            .covered  (covered[h])
        );
    end

    hsne_encode u_encode (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (s2_take),
        .covered     (covered_reg),
        .air_level   (air_reg),
        .elapsed_ms  (elapsed_reg),
        .root_note   (root_reg),
        .debounce_ms (debounce_reg),
        .push        (push)
    );

    hsne_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (s2_take),
        .push    (push),
        .status  (fifo_st),
        .msg     (msg)
    );

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_st.level <= hsne_pkg::LVL_W'(hsne_pkg::FIFO_DEPTH))
        else $error("message queue overflow");

    a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!s1_valid_reg || s2_take))
        else $error("word accepted over a held scan");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_take) |=> s1_valid_reg)
        else $error("stalled scan dropped");

    a_cal_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_cnt_reg < hsne_pkg::CALCNT_W'(hsne_pkg::CAL_SAMPLES))
        else $error("calibration count out of range");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_take && (push.cnt != '0)) |=> (fifo_st.level != '0))
        else $error("pushed messages missing from queue");

endmodule
